[src/ksaes_pkg.sv]
// Package for the keyed-shuffle AES-128 block cipher: types, tables and round functions.
// Used by ksaes_ctrl, ksaes_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ksaes_pkg;

    localparam int NumRounds  = 10;
    localparam int NumKeys    = NumRounds + 1;
    localparam int KeyIdxW    = $clog2(NumKeys);
    localparam int BitIdxW    = 5;
    localparam int CfgIdxW    = 3;
    localparam logic [31:0] LcgMul = 32'd1664525;
    localparam logic [31:0] LcgAdd = 32'd1013904223;

    localparam logic [CfgIdxW-1:0] REG_KEY_HIGH    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_KEY_LOW     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SECRET_HIGH = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SECRET_LOW  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_VARIANT     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXPAND, ST_LCG, ST_MOD, ST_SWAP, ST_INIT, ST_ROUND, ST_DONE
    } state_t;

    typedef struct packed {
        logic               load;
        logic               exp_step;
        logic [KeyIdxW-1:0] kidx;
        logic               lcg_step;
        logic               mod_step;
        logic [BitIdxW-1:0] bit_idx;
        logic               swap;
        logic [KeyIdxW-1:0] step;
        logic               init_add;
        logic               round_step;
        logic [KeyIdxW-1:0] round;
        logic               last;
        logic               out_load;
        logic               derive_done;
    } cmd_t;

    typedef struct packed {
        logic sched_ready;
        logic variant;
        logic mode;
        logic out_busy;
    } sts_t;

    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte 0 sits in the top bits of the 128-bit state
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127-8*(r+4*c) -: 8] = SBOX[s[127-8*(r+4*((c+r)%4)) -: 8]];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127-8*(r+4*((c+r)%4)) -: 8] = INV_SBOX[s[127-8*(r+4*c) -: 8]];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a [4];
        logic [7:0]   all;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = s[127-8*(r+4*c) -: 8];
            all = a[0] ^ a[1] ^ a[2] ^ a[3];
            for (int r = 0; r < 4; r++) begin
                o[127-8*(r+4*c) -: 8] = a[r] ^ all ^ xt(a[r] ^ a[(r+1)%4]);
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a2 [4];
        logic [7:0]   a4 [4];
        logic [7:0]   a8 [4];
        logic [7:0]   a1 [4];
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a1[r] = s[127-8*(r+4*c) -: 8];
                a2[r] = xt(a1[r]);
                a4[r] = xt(a2[r]);
                a8[r] = xt(a4[r]);
            end
            for (int r = 0; r < 4; r++) begin
                o[127-8*(r+4*c) -: 8] =
                    (a8[r] ^ a4[r] ^ a2[r]) ^
                    (a8[(r+1)%4] ^ a2[(r+1)%4] ^ a1[(r+1)%4]) ^
                    (a8[(r+2)%4] ^ a4[(r+2)%4] ^ a1[(r+2)%4]) ^
                    (a8[(r+3)%4] ^ a1[(r+3)%4]);
            end
        end
        return o;
    endfunction

    // (v % 9) + 1 via reciprocal multiply, exact for 8-bit v
    function automatic logic [3:0] pick_round(input logic [7:0] v);
        logic [13:0] p;
        logic [4:0]  q;
        logic [7:0]  r;
        p = 14'(v) * 14'd57;
        q = p[13:9];
        r = v - 8'(q) * 8'd9;
        return r[3:0] + 4'd1;
    endfunction

endpackage
`default_nettype wire

[src/ksaes_ctrl.sv]
// Sequencer for the keyed-shuffle AES-128 core: key expansion, shuffle, rounds, output.
// Depends on ksaes_pkg; drives ksaes_datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none
module ksaes_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire ksaes_pkg::sts_t sts,
    output ksaes_pkg::cmd_t     cmd
);
    import ksaes_pkg::*;

    state_t               state_reg, state_next;
    logic [KeyIdxW-1:0]   cnt_reg, cnt_next;
    logic [BitIdxW-1:0]   bit_reg, bit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sts.sched_ready ? ST_INIT : ST_EXPAND;
                    cnt_next   = KeyIdxW'(1);
                end
            end
            ST_EXPAND: begin
                if (cnt_reg == KeyIdxW'(NumRounds)) begin
                    state_next = sts.variant ? ST_LCG : ST_INIT;
                end else begin
                    cnt_next = cnt_reg + KeyIdxW'(1);
                end
            end
            ST_LCG: begin
                state_next = ST_MOD;
                bit_next   = '1;
            end
            ST_MOD: begin
                if (bit_reg == '0) state_next = ST_SWAP;
                else bit_next = bit_reg - BitIdxW'(1);
            end
            ST_SWAP: begin
                if (cnt_reg == KeyIdxW'(1)) begin
                    state_next = ST_INIT;
                end else begin
                    state_next = ST_LCG;
                    cnt_next   = cnt_reg - KeyIdxW'(1);
                end
            end
            ST_INIT: begin
                state_next = ST_ROUND;
                cnt_next   = KeyIdxW'(1);
            end
            ST_ROUND: begin
                if (cnt_reg == KeyIdxW'(NumRounds)) state_next = ST_DONE;
                else cnt_next = cnt_reg + KeyIdxW'(1);
            end
            ST_DONE: begin
                if (!sts.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.kidx    = cnt_reg;
        cmd.step    = cnt_reg;
        cmd.bit_idx = bit_reg;
        cmd.last    = (cnt_reg == KeyIdxW'(NumRounds));
        cmd.round   = sts.mode ? KeyIdxW'(NumRounds) - cnt_reg : cnt_reg;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_EXPAND: begin
                cmd.exp_step    = 1'b1;
                cmd.derive_done = (cnt_reg == KeyIdxW'(NumRounds)) && !sts.variant;
            end
            ST_LCG:  cmd.lcg_step = 1'b1;
            ST_MOD:  cmd.mod_step = 1'b1;
            ST_SWAP: begin
                cmd.swap        = 1'b1;
                cmd.derive_done = (cnt_reg == KeyIdxW'(1));
            end
            ST_INIT: begin
                cmd.init_add = 1'b1;
                cmd.round    = sts.mode ? KeyIdxW'(NumRounds) : '0;
            end
            ST_ROUND: cmd.round_step = 1'b1;
            ST_DONE:  cmd.out_load   = !sts.out_busy;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[src/ksaes_datapath.sv]
// Datapath: configuration registers, round key store, shuffle unit, shared round logic.
// Depends on ksaes_pkg; sequenced by ksaes_ctrl through cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module ksaes_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic [ksaes_pkg::CfgIdxW-1:0]     cfg_index,
    input  wire logic [63:0]                       cfg_data,
    input  wire logic                              in_mode,
    input  wire logic [127:0]                      in_block,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [127:0]                           out_block,
    input  wire ksaes_pkg::cmd_t                   cmd,
    output ksaes_pkg::sts_t                        sts
);
    import ksaes_pkg::*;

    logic [63:0]  key_high_reg, key_low_reg, secret_high_reg, secret_low_reg;
    logic         variant_reg;
    logic         sched_ready_reg;
    logic         out_valid_reg;
    logic [127:0] out_reg;
    logic         mode_reg;
    logic [127:0] state_reg, state_next;
    logic [127:0] last_key_reg, new_key;
    logic [127:0] rk_reg [NumKeys];
    logic [KeyIdxW-1:0] perm_reg [NumKeys];
    logic [31:0]  x_reg;
    logic [KeyIdxW-1:0] rem_reg;
    logic [KeyIdxW:0]   rem_shift, divisor;
    logic [31:0]  t_word;
    logic [3:0]   alt_round;
    logic [127:0] round_key;
    logic [127:0] fwd, inv;
    logic         cfg_hit;

    assign cfg_hit = cfg_valid && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW ||
                     cfg_index == REG_SECRET_HIGH || cfg_index == REG_SECRET_LOW ||
                     cfg_index == REG_VARIANT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg    <= '0;
            key_low_reg     <= '0;
            secret_high_reg <= '0;
            secret_low_reg  <= '0;
            variant_reg     <= 1'b0;
            sched_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_KEY_HIGH:    key_high_reg    <= cfg_data;
                    REG_KEY_LOW:     key_low_reg     <= cfg_data;
                    REG_SECRET_HIGH: secret_high_reg <= cfg_data;
                    REG_SECRET_LOW:  secret_low_reg  <= cfg_data;
                    REG_VARIANT:     variant_reg     <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cfg_hit) sched_ready_reg <= 1'b0;
            else if (cmd.derive_done) sched_ready_reg <= 1'b1;
            if (cmd.out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    // next round key: RotWord/SubWord on the last word, then chained XORs
    assign t_word = {SBOX[last_key_reg[23:16]] ^ RCON[cmd.kidx - KeyIdxW'(1)],
                     SBOX[last_key_reg[15:8]], SBOX[last_key_reg[7:0]],
                     SBOX[last_key_reg[31:24]]};
    always_comb begin
        new_key[127:96] = last_key_reg[127:96] ^ t_word;
        new_key[95:64]  = last_key_reg[95:64] ^ new_key[127:96];
        new_key[63:32]  = last_key_reg[63:32] ^ new_key[95:64];
        new_key[31:0]   = last_key_reg[31:0] ^ new_key[63:32];
    end

    // restoring remainder, one bit of x per cycle
    assign divisor   = {1'b0, cmd.step} + (KeyIdxW+1)'(1);
    assign rem_shift = {rem_reg, x_reg[cmd.bit_idx]};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= in_mode;
            state_reg <= in_block;
            if (!sched_ready_reg) begin
                rk_reg[0]    <= {key_high_reg, key_low_reg};
                last_key_reg <= {key_high_reg, key_low_reg};
                x_reg <= {secret_high_reg[7:0], secret_high_reg[15:8],
                          secret_high_reg[23:16], secret_high_reg[31:24]};
                for (int i = 0; i < NumKeys; i++) perm_reg[i] <= KeyIdxW'(i);
            end
        end
        if (cmd.exp_step) begin
            rk_reg[cmd.kidx] <= new_key;
            last_key_reg     <= new_key;
        end
        if (cmd.lcg_step) begin
            x_reg   <= x_reg * LcgMul + LcgAdd;
            rem_reg <= '0;
        end
        if (cmd.mod_step) begin
            if (rem_shift >= divisor) rem_reg <= KeyIdxW'(rem_shift - divisor);
            else rem_reg <= KeyIdxW'(rem_shift);
        end
        if (cmd.swap) begin
            perm_reg[cmd.step] <= perm_reg[rem_reg];
            perm_reg[rem_reg]  <= perm_reg[cmd.step];
        end
        if (cmd.init_add || cmd.round_step) state_reg <= state_next;
        if (cmd.out_load) out_reg <= state_reg;
    end

    assign alt_round = pick_round(secret_high_reg[63:56] ^ secret_high_reg[55:48] ^
                                  secret_high_reg[47:40] ^ secret_high_reg[39:32]);

    always_comb begin
        round_key = rk_reg[perm_reg[cmd.round]];
        if (variant_reg && cmd.round == alt_round) begin
            round_key = round_key ^ {secret_low_reg, secret_low_reg};
        end
    end

    always_comb begin
        fwd = sub_shift(state_reg);
        if (!cmd.last) fwd = mix(fwd);
        fwd = fwd ^ round_key;
        inv = inv_sub_shift(state_reg) ^ round_key;
        if (!cmd.last) inv = inv_mix(inv);
        priority if (cmd.init_add) state_next = state_reg ^ round_key;
        else if (mode_reg)         state_next = inv;
        else                       state_next = fwd;
    end

    assign m_tvalid  = out_valid_reg;
    assign out_block = out_reg;
    assign sts.sched_ready = sched_ready_reg;
    assign sts.variant     = variant_reg;
    assign sts.mode        = mode_reg;
    assign sts.out_busy    = out_valid_reg && !m_tready;

    a_swap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap |-> rem_reg <= cmd.step)
        else $error("shuffle swap index beyond step");
    a_ready_after_derive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.derive_done && !cfg_hit |=> sched_ready_reg)
        else $error("schedule not marked ready after derivation");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !out_valid_reg || m_tready)
        else $error("result overwritten before taken");

endmodule
`default_nettype wire

[src/keyed_shuffle_aes128_block_cipher.sv]
// AES-128 single-block encrypt/decrypt with optional keyed round-key shuffle.
// Top level; depends on ksaes_pkg, ksaes_ctrl and ksaes_datapath.
//
// One transaction in, one out. A block passes through accept, initial key addition,
// ten rounds on one shared round unit and output load; the output load waits until
// the receiver has taken the previous result, and the next block can be accepted
// once the result is in the output register. The first block after reset or any
// write to a defined configuration register first rebuilds the round keys: key
// expansion, then the shuffle when the variant is enabled (ten LCG steps, each with
// a bit-serial remainder over the 32-bit LCG state and a swap).
`timescale 1ns / 1ps
`default_nettype none
module keyed_shuffle_aes128_block_cipher (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ksaes_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [127:0]                  s_tdata,  // block_high, block_low
    input  wire logic [0:0]                    s_tuser,  // mode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [127:0]                       m_tdata   // result_high, result_low
);
    import ksaes_pkg::*;

    cmd_t         cmd;
    sts_t         sts;
    logic [127:0] out_block;

    assign cfg_ready = 1'b1;

    ksaes_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ksaes_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_mode   (s_tuser[0]),
        .in_block  ({s_tdata[63:0], s_tdata[127:64]}),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_block (out_block),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign m_tdata = {out_block[63:0], out_block[127:64]};

endmodule
`default_nettype wire

[verif/keyed_shuffle_aes128_block_cipher_tb.sv]
// Self-checking testbench for the keyed-shuffle AES-128 block cipher top level.
// Carries its own AES-128 predictor (key expansion, shuffle, altered round); needs ksaes_pkg.
`timescale 1ns / 1ps
module keyed_shuffle_aes128_block_cipher_tb;
    import ksaes_pkg::*;

    localparam int IdleLimit = 3000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [63:0]         cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [127:0]        s_tdata = '0;  // block_high, block_low
    logic [0:0]          s_tuser = '0;  // mode
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [127:0]        m_tdata;       // result_high, result_low

    keyed_shuffle_aes128_block_cipher u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    // predictor state
    logic [7:0]   fwd_sub [256];
    logic [7:0]   inv_sub [256];
    logic [63:0]  key_hi, key_lo, sec_hi, sec_lo;
    logic         variant_on;
    bit           keys_valid;
    logic [127:0] sched_keys [11];
    logic [127:0] masked_key;
    int           masked_round;

    logic [127:0] cipher_q [$];  // expected {result_high, result_low}
    int           fails = 0;
    int           idle_cycles = 0;
    int           rx_hold = 0;
    bit           quiet = 1'b0;

    typedef struct {
        bit           is_cfg;
        logic [2:0]   idx;
        logic [63:0]  wdata;
        logic         mode;
        logic [63:0]  hi;
        logic [63:0]  lo;
        bit           known;
        logic [127:0] want;
    } vec_t;
    vec_t vectors [$];

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = xtime(a);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] key_for(input int r);
        if (variant_on && r == masked_round) return masked_key;
        return sched_keys[r];
    endfunction

    function automatic logic [127:0] sub_rows(input logic [127:0] s, input bit inv);
        logic [127:0] o;
        o = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (!inv) o[127-8*(r+4*c) -: 8] = fwd_sub[byte_at(s, r+4*((c+r)%4))];
                else o[127-8*(r+4*((c+r)%4)) -: 8] = inv_sub[byte_at(s, r+4*c)];
        return o;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit inv);
        logic [127:0] o;
        logic [7:0]   a [4];
        logic [7:0]   all;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = byte_at(s, r+4*c);
            all = a[0] ^ a[1] ^ a[2] ^ a[3];
            for (int r = 0; r < 4; r++)
                if (!inv) o[127-8*(r+4*c) -: 8] = a[r] ^ all ^ xtime(a[r] ^ a[(r+1)%4]);
                else o[127-8*(r+4*c) -: 8] = gf_mul(a[r], 8'h0e) ^ gf_mul(a[(r+1)%4], 8'h0b)
                                           ^ gf_mul(a[(r+2)%4], 8'h0d) ^ gf_mul(a[(r+3)%4], 8'h09);
        end
        return o;
    endfunction

    function automatic void build_sboxes();
        logic [7:0] b, y;
        for (int x = 0; x < 256; x++) begin
            b = 8'h00;
            for (int k = 1; k < 256; k++)
                if (x != 0 && gf_mul(8'(x), 8'(k)) == 8'h01) b = 8'(k);
            y = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]} ^ 8'h63;
            fwd_sub[x] = y;
            inv_sub[y] = 8'(x);
        end
    endfunction

    function automatic void expand_keys();
        logic [31:0]  w [44];
        logic [31:0]  t, lcg;
        logic [127:0] key, tmp [11];
        logic [7:0]   rc, sel;
        int           perm [11];
        int           j, s;
        key = {key_hi, key_lo};
        rc = 8'h01;
        for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {fwd_sub[t[23:16]] ^ rc, fwd_sub[t[15:8]], fwd_sub[t[7:0]], fwd_sub[t[31:24]]};
                rc = xtime(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++) sched_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        sel = sec_hi[63:56] ^ sec_hi[55:48] ^ sec_hi[47:40] ^ sec_hi[39:32];
        masked_round = int'(sel) % 9 + 1;
        masked_key = '0;
        if (variant_on) begin
            lcg = {sec_hi[7:0], sec_hi[15:8], sec_hi[23:16], sec_hi[31:24]};
            for (int i = 0; i < 11; i++) perm[i] = i;
            for (int i = 10; i > 0; i--) begin
                lcg = lcg * LcgMul + LcgAdd;
                j = int'(lcg % 32'(i + 1));
                s = perm[i]; perm[i] = perm[j]; perm[j] = s;
            end
            for (int i = 0; i < 11; i++) tmp[i] = sched_keys[perm[i]];
            for (int i = 0; i < 11; i++) sched_keys[i] = tmp[i];
            masked_key = sched_keys[masked_round] ^ {sec_lo, sec_lo};
        end
        keys_valid = 1'b1;
    endfunction

    function automatic logic [127:0] cipher_block(input logic m, input logic [127:0] s);
        if (!keys_valid) expand_keys();
        if (!m) begin
            s ^= key_for(0);
            for (int r = 1; r < 10; r++) s = mix_columns(sub_rows(s, 0), 0) ^ key_for(r);
            s = sub_rows(s, 0) ^ key_for(10);
        end else begin
            s ^= key_for(10);
            for (int r = 9; r > 0; r--) s = mix_columns(sub_rows(s, 1) ^ key_for(r), 1);
            s = sub_rows(s, 1) ^ key_for(0);
        end
        return s;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (fails < 100) $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    task automatic send_block(input logic m, input logic [63:0] hi, input logic [63:0] lo,
                              input bit known, input logic [127:0] want);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {lo, hi};
        do @(posedge aclk); while (!s_tready);
        cipher_q.push_back(known ? want : cipher_block(m, {hi, lo}));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        s_tvalid <= 1'b0;
        wait (cipher_q.size() == 0);
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KEY_HIGH:    key_hi = val;
            REG_KEY_LOW:     key_lo = val;
            REG_SECRET_HIGH: sec_hi = val;
            REG_SECRET_LOW:  sec_lo = val;
            REG_VARIANT:     variant_on = val[0];
            default:         return;  // out-of-range index is dropped
        endcase
        keys_valid = 1'b0;
    endtask

    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 5))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic add_cfg(input logic [2:0] idx, input logic [63:0] val);
        vec_t v;
        v = '{1'b1, idx, val, 1'b0, 64'h0, 64'h0, 1'b0, 128'h0};
        vectors.push_back(v);
    endtask

    task automatic add_item(input logic m, input logic [63:0] hi, input logic [63:0] lo,
                            input bit known, input logic [127:0] want);
        vec_t v;
        v = '{1'b0, 3'd0, 64'h0, m, hi, lo, known, want};
        vectors.push_back(v);
    endtask

    // receiver: random back-pressure plus a requested long hold-off
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                n = rx_hold;
                rx_hold = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        logic [127:0] want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (cipher_q.size() == 0) begin
                    report("unexpected result", m_tdata[63:0], 64'h0);
                end else begin
                    want = cipher_q.pop_front();
                    if (m_tdata[63:0] !== want[127:64])
                        report("result_high", m_tdata[63:0], want[127:64]);
                    if (m_tdata[127:64] !== want[63:0])
                        report("result_low", m_tdata[127:64], want[63:0]);
                end
            end
            if (idle_cycles >= IdleLimit) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int n_items;
        logic [63:0] h, l;
        build_sboxes();
        key_hi = '0; key_lo = '0; sec_hi = '0; sec_lo = '0;
        variant_on = 1'b0;
        keys_valid = 1'b0;

        // directed: known vectors, extremes, ignored writes, variant corners
        add_item(1'b0, 64'h0, 64'h0, 1, 128'h66e94bd4ef8a2c3b_884cfa59ca342b2e);
        add_item(1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 128'h0);
        add_item(1'b0, '1, '1, 0, '0);
        add_item(1'b1, '1, '1, 0, '0);
        add_cfg(REG_KEY_HIGH, 64'h0001020304050607);
        add_cfg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        add_item(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
                 128'h69c4e0d86a7b0430_d8cdb78070b4c55a);
        add_item(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
                 128'h00112233445566778899aabbccddeeff);
        add_cfg(3'd7, '1);
        add_cfg(3'd5, 64'h1234);
        add_item(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
                 128'h69c4e0d86a7b0430_d8cdb78070b4c55a);
        add_cfg(REG_SECRET_HIGH, '1);
        add_cfg(REG_SECRET_LOW, '1);
        add_cfg(REG_VARIANT, 64'h1);
        add_item(1'b0, 64'h0, 64'h0, 0, '0);
        add_item(1'b1, '1, '1, 0, '0);
        add_cfg(REG_SECRET_HIGH, 64'h0);
        add_cfg(REG_SECRET_LOW, 64'h0123456789abcdef);
        add_item(1'b0, 64'h8000000000000001, 64'h7ffffffffffffffe, 0, '0);
        add_item(1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff, 0, '0);
        add_cfg(REG_KEY_HIGH, '1);
        add_cfg(REG_KEY_LOW, '1);
        add_item(1'b0, '1, 64'h0, 0, '0);
        add_cfg(REG_VARIANT, 64'hfffffffffffffffe);
        add_item(1'b1, 64'h0, '1, 0, '0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (vectors[i]) begin
            if (vectors[i].is_cfg) write_reg(vectors[i].idx, vectors[i].wdata);
            else send_block(vectors[i].mode, vectors[i].hi, vectors[i].lo,
                            vectors[i].known, vectors[i].want);
        end

        // random phases: the first writes all five configuration registers, later ones a random subset
        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < 5; r++)
                if (ph == 0 || $urandom_range(0, 2) != 0)
                    write_reg(3'(r), (r == 4) ? 64'($urandom_range(0, 1)) : pick64());
            if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(5, 7)), pick64());
            if (ph == 7) quiet = 1'b1;
            n_items = (ph == 7) ? 130 : 215;
            for (int k = 0; k < n_items; k++) begin
                if (ph == 2 && k == 40) rx_hold = 400;
                if (ph == 4 && k == 100) begin
                    s_tvalid <= 1'b0;
                    wait (cipher_q.size() == 0);
                    @(posedge aclk);
                end
                h = ($urandom_range(0, 15) == 0) ? pick64() : {$urandom, $urandom};
                l = ($urandom_range(0, 15) == 0) ? pick64() : {$urandom, $urandom};
                send_block(1'($urandom_range(0, 1)), h, l, 0, '0);
            end
        end

        s_tvalid <= 1'b0;
        wait (cipher_q.size() == 0);
        repeat (30) @(posedge aclk);
        if (fails == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

[files.f]
src/ksaes_pkg.sv
src/ksaes_ctrl.sv
src/ksaes_datapath.sv
src/keyed_shuffle_aes128_block_cipher.sv
verif/keyed_shuffle_aes128_block_cipher_tb.sv
